### rtl/core/contiguous_fit_allocator_unit_defines.svh
// Assertion macros of the allocator RTL.
`ifndef CONTIGUOUS_FIT_ALLOCATOR_UNIT_DEFINES_SVH
`define CONTIGUOUS_FIT_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CFA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CFA_ASSERT_SAME(label, ante, cons)
`define CFA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/core/cfa_pkg.sv
// Shared constants, codes and control types of the contiguous fit allocator.
package cfa_pkg;
  localparam int MEM_UNITS = 256;
  localparam int AW        = $clog2(MEM_UNITS);
  localparam int CW        = AW + 1;
  localparam int LIFE_W    = 16;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_FRAG  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] ST_FIRST = 2'd0;
  localparam logic [1:0] ST_NEXT  = 2'd1;
  localparam logic [1:0] ST_BEST  = 2'd2;

  localparam logic CFG_STRATEGY = 1'b0;
  localparam logic CFG_UNITS    = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MOD  = 5'b00010,
    S_SCAN = 5'b00100,
    S_FILL = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  typedef struct packed {
    logic latch;
    logic mod_step;
    logic scan;
    logic fill;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic mod_done;
    logic scan_done;
    logic fill_req;
    logic fill_last;
  } sts_t;
endpackage

### rtl/core/cfa_ctrl.sv
// Sequencer of the allocator: position reduce, unit scan, hole fill, result.
`include "contiguous_fit_allocator_unit_defines.svh"
module cfa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  cfa_pkg::sts_t sts,
  output cfa_pkg::cmd_t cmd
);
  cfa_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == cfa_pkg::S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;

  // Decode state into commands and pick the next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      cfa_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.latch = 1'b1;
          state_nxt = cfa_pkg::S_MOD;
        end
      end
      cfa_pkg::S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_done) state_nxt = cfa_pkg::S_SCAN;
      end
      cfa_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = sts.fill_req ? cfa_pkg::S_FILL : cfa_pkg::S_FIN;
      end
      cfa_pkg::S_FILL: begin
        cmd.fill = 1'b1;
        if (sts.fill_last) state_nxt = cfa_pkg::S_FIN;
      end
      cfa_pkg::S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = cfa_pkg::S_IDLE;
      end
      default: state_nxt = cfa_pkg::S_IDLE;
    endcase
  end

  // Hold the result until its transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.finish) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfa_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `CFA_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, state_r != cfa_pkg::S_IDLE)
  `CFA_ASSERT_SAME(a_ready_free, in_ready, !out_valid_r)
  `CFA_ASSERT_NEXT(a_fin_valid, state_r == cfa_pkg::S_FIN, out_valid_r)
endmodule

### rtl/core/cfa_dp.sv
// Datapath: lifetime store, scan pipeline, hole tracking and fill writer.
module cfa_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfa_pkg::cmd_t             cmd,
  output cfa_pkg::sts_t             sts,
  input  logic [1:0]                in_opcode,
  input  logic [8:0]                in_request_units,
  input  logic [15:0]               in_lifetime,
  input  logic [8:0]                in_fragment_limit,
  input  logic [1:0]                strategy,
  input  logic [8:0]                units_in_use,
  output logic                      out_status,
  output logic [8:0]                out_probe_count,
  output logic [7:0]                out_fragment_total
);
  localparam int AW = cfa_pkg::AW;
  localparam int CW = cfa_pkg::CW;
  localparam int LW = cfa_pkg::LIFE_W;

  logic [LW-1:0] mem_r [cfa_pkg::MEM_UNITS];
  logic [cfa_pkg::MEM_UNITS-1:0] vld_r;
  logic [LW-1:0] rd_data_r;
  logic          vbit_r;

  logic [1:0]    op_r, strat_r;
  logic [8:0]    size_r, limit_r;
  logic [LW-1:0] life_r;
  logic [CW-1:0] n_r, i_r, d_i_r, run_r, pr_r, bsize_r, fcnt_r;
  logic [AW-1:0] p_r, pos_r, d_q_r, start_r, bstart_r;
  logic          d_vld_r, stop_r, found_r;
  logic [7:0]    frag_r;
  logic          status_r;
  logic [8:0]    probe_r;
  logic [7:0]    fragout_r;

  logic [CW-1:0] n_in, sum, qfull, run_in, run_inc, run_eff, pr_in;
  logic [AW-1:0] q, start_eff;
  logic          issue, proc, wrap, free, last, hole_end, is_alloc;
  logic [LW-1:0] val;
  logic          we;
  logic [AW-1:0] waddr;
  logic [LW-1:0] wdata;
  logic [CW-1:0] run_nxt, pr_nxt, bsize_nxt;
  logic [AW-1:0] start_nxt, bstart_nxt;
  logic          stop_nxt, found_nxt;
  logic [7:0]    frag_nxt;

  // Clamp the managed unit count
  always_comb begin
    n_in = units_in_use;
    if (units_in_use == '0) n_in = CW'(1);
    if (units_in_use > CW'(cfa_pkg::MEM_UNITS)) n_in = CW'(cfa_pkg::MEM_UNITS);
  end

  assign is_alloc = (op_r == cfa_pkg::OP_ALLOC);

  // Circular read address for the scan
  assign sum   = {1'b0, p_r} + i_r;
  assign qfull = (sum >= n_r) ? sum - n_r : sum;
  assign q     = qfull[AW-1:0];
  assign issue = cmd.scan && !stop_r && (i_r < n_r);
  assign proc  = cmd.scan && d_vld_r && !stop_r;

  // Examine one returned unit
  always_comb begin
    val       = vbit_r ? rd_data_r : '0;
    free      = (val == '0);
    last      = (d_i_r == n_r - CW'(1));
    wrap      = (d_q_r == '0) && (d_i_r != '0);
    run_in    = wrap ? '0 : run_r;
    pr_in     = pr_r + CW'(wrap && (run_r != '0));
    run_inc   = run_in + CW'(1);
    run_eff   = free ? run_inc : run_in;
    start_eff = (run_in == '0) ? d_q_r : start_r;
    hole_end  = (free && last) || (!free && (run_in != '0));
    run_nxt    = run_r;
    pr_nxt     = pr_r;
    start_nxt  = start_r;
    bstart_nxt = bstart_r;
    bsize_nxt  = bsize_r;
    stop_nxt   = stop_r;
    found_nxt  = found_r;
    frag_nxt   = frag_r;
    we    = 1'b0;
    waddr = d_q_r;
    wdata = val - LW'(1);
    if (proc) begin
      run_nxt = free ? run_inc : '0;
      pr_nxt  = pr_in;
      if (free) start_nxt = start_eff;
      case (op_r)
        cfa_pkg::OP_ALLOC: begin
          if (strat_r == cfa_pkg::ST_BEST) begin
            if (hole_end) begin
              pr_nxt = pr_in + CW'(1);
              if ({1'b0, run_eff} >= {1'b0, size_r} &&
                  (!found_r || run_eff < bsize_r)) begin
                found_nxt  = 1'b1;
                bsize_nxt  = run_eff;
                bstart_nxt = start_eff;
              end
              if (run_eff == size_r) stop_nxt = 1'b1;
            end
          end else begin
            if (free && run_inc == size_r) begin
              found_nxt  = 1'b1;
              stop_nxt   = 1'b1;
              bstart_nxt = start_eff;
              pr_nxt     = pr_in + CW'(1);
            end else if (!free && run_in != '0) begin
              pr_nxt = pr_in + CW'(1);
            end
          end
        end
        cfa_pkg::OP_TICK: begin
          we = !free;
        end
        cfa_pkg::OP_FRAG: begin
          if (free) begin
            if (last && run_inc <= limit_r) frag_nxt = frag_r + 8'd1;
          end else if (run_in != '0 && run_in <= limit_r) begin
            frag_nxt = frag_r + 8'd1;
          end
        end
        default: ;
      endcase
    end
    // Write the placement one unit a cycle
    if (cmd.fill) begin
      we    = 1'b1;
      waddr = bstart_r + fcnt_r[AW-1:0];
      wdata = life_r;
    end
  end

  assign sts.mod_done  = ({1'b0, p_r} < n_r);
  assign sts.scan_done = stop_r || ((i_r == n_r) && !d_vld_r);
  assign sts.fill_req  = is_alloc && found_r;
  assign sts.fill_last = (fcnt_r == size_r - CW'(1));

  // Store and read port
  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rd_data_r <= mem_r[q];
    vbit_r    <= vld_r[q];
  end

  // Valid bits: cleared by reset and by clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.finish && op_r == cfa_pkg::OP_CLEAR) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  // Scan control and persistent next fit position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      d_vld_r <= 1'b0;
    end else begin
      d_vld_r <= issue;
      if (cmd.latch) d_vld_r <= 1'b0;
      if (cmd.finish) begin
        if (op_r == cfa_pkg::OP_CLEAR) pos_r <= '0;
        else if (is_alloc && found_r && strat_r == cfa_pkg::ST_NEXT)
          pos_r <= bstart_r + AW'(size_r - 9'd1);
      end
    end
  end

  // Capture the item, then advance the scan
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r    <= in_opcode;
      strat_r <= strategy;
      size_r  <= in_request_units;
      life_r  <= in_lifetime;
      limit_r <= in_fragment_limit;
      n_r     <= n_in;
      // Only a next fit allocate starts the scan at the saved position
      p_r     <= (strategy == cfa_pkg::ST_NEXT && in_opcode == cfa_pkg::OP_ALLOC) ?
                 pos_r : '0;
      i_r     <= '0;
      run_r   <= '0;
      pr_r    <= '0;
      start_r <= '0;
      bstart_r <= '0;
      bsize_r <= '0;
      found_r <= 1'b0;
      frag_r  <= '0;
      fcnt_r  <= '0;
      stop_r  <= (in_opcode == cfa_pkg::OP_ALLOC) &&
                 ((in_request_units == '0) || (strategy != cfa_pkg::ST_FIRST &&
                  strategy != cfa_pkg::ST_NEXT && strategy != cfa_pkg::ST_BEST));
    end else begin
      if (cmd.mod_step && !sts.mod_done) p_r <= AW'({1'b0, p_r} - n_r);
      if (issue) begin
        i_r   <= i_r + CW'(1);
        d_i_r <= i_r;
        d_q_r <= q;
      end
      run_r    <= run_nxt;
      pr_r     <= pr_nxt;
      start_r  <= start_nxt;
      bstart_r <= bstart_nxt;
      bsize_r  <= bsize_nxt;
      stop_r   <= stop_nxt;
      found_r  <= found_nxt;
      frag_r   <= frag_nxt;
      if (cmd.fill) fcnt_r <= fcnt_r + CW'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status_r  <= is_alloc && !found_r;
      probe_r   <= (is_alloc && found_r) ? pr_r : '0;
      fragout_r <= (op_r == cfa_pkg::OP_FRAG) ? frag_r : '0;
    end
  end

  assign out_status         = status_r;
  assign out_probe_count    = probe_r;
  assign out_fragment_total = fragout_r;
endmodule

### rtl/core/contiguous_fit_allocator_unit.sv
// Contiguous fit allocator: one item is in work at a time.
// Steps: reduce the next fit position by repeated subtraction, scan the managed units
//   through the store's read port, fill request_units units on a placement and then
//   register the result. A new item is accepted only after the last result is transferred.
// Reset (rst_n low, synchronous): all units free, position zero, first fit, 256 units.
module contiguous_fit_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [8:0]  in_request_units,
  input  logic [15:0] in_lifetime,
  input  logic [8:0]  in_fragment_limit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_status,
  output logic [8:0]  out_probe_count,
  output logic [7:0]  out_fragment_total,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_wdata
);
  logic [1:0] strategy_r;
  logic [8:0] units_r;
  cfa_pkg::cmd_t cmd;
  cfa_pkg::sts_t sts;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strategy_r <= cfa_pkg::ST_FIRST;
      units_r    <= 9'(cfa_pkg::MEM_UNITS);
    end else if (cfg_we) begin
      if (cfg_index == cfa_pkg::CFG_STRATEGY) strategy_r <= cfg_wdata[1:0];
      else if (cfg_index == cfa_pkg::CFG_UNITS) units_r <= cfg_wdata;
    end
  end

  cfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cfa_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_opcode          (in_opcode),
    .in_request_units   (in_request_units),
    .in_lifetime        (in_lifetime),
    .in_fragment_limit  (in_fragment_limit),
    .strategy           (strategy_r),
    .units_in_use       (units_r),
    .out_status         (out_status),
    .out_probe_count    (out_probe_count),
    .out_fragment_total (out_fragment_total)
  );
endmodule
